[sv/crc16fr_pkg.sv]
package crc16fr_pkg;

  // Frame format constants.
  localparam int unsigned FRAME_OVERHEAD  = 5;
  localparam int unsigned MAX_FRAME_BYTES = 1024;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned IDX_W   = 1;

  // CRC-16/XMODEM polynomial.
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Register reset values, the frame length cap and the overhead total.
  localparam logic [BYTE_W-1:0]  SYNC_RESET      = 8'hA5;
  localparam logic [LIMIT_W-1:0] MAX_LEN_RESET   = 11'd1024;
  localparam logic [LIMIT_W-1:0] MAX_FRAME_LIMIT = LIMIT_W'(MAX_FRAME_BYTES);
  localparam logic [TOTAL_W-1:0] OVERHEAD_TOTAL  = TOTAL_W'(FRAME_OVERHEAD);

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_SYNC_BYTE     = 1'b0,
    REG_MAX_FRAME_LEN = 1'b1
  } cfg_reg_t;

  // Receive phase.
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  // One byte of the CRC, MSB first, eight shift steps.
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

[sv/crc16fr_if.sv]
// Received byte channel.
interface crc16fr_rx_if;
  logic                             valid;
  logic                             ready;
  logic [crc16fr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: one echoed frame byte with its flags.
interface crc16fr_res_if;
  logic                             valid;
  logic                             ready;
  logic [crc16fr_pkg::BYTE_W-1:0]   byte_out;
  logic [crc16fr_pkg::POS_W-1:0]    byte_pos;
  logic                             is_payload;
  logic                             frame_end;
  logic                             crc_match;
  logic                             len_error;

  modport source (output valid, output byte_out, output byte_pos, output is_payload,
                  output frame_end, output crc_match, output len_error, input ready);
  modport sink   (input valid, input byte_out, input byte_pos, input is_payload,
                  input frame_end, input crc_match, input len_error, output ready);
endinterface

// Configuration write channel.
interface crc16fr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crc16fr_pkg::IDX_W-1:0]    index;
  logic [crc16fr_pkg::LIMIT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/crc16_frame_receiver_top.sv]
// A result is registered: it appears in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle; the bytewise CRC update and the length check
// sit between the input handshake and the result register.
// Input is taken while the result register is empty or transferring; a held result stalls it.
// Reset (synchronous, active high) returns to sync hunting, clears the CRC and
// counters, and loads sync byte 0xA5 and a maximum frame length of 1024.
module crc16_frame_receiver_top (
  input logic          clk,
  input logic          rst,
  crc16fr_cfg_if.sink  cfg,
  crc16fr_rx_if.sink   rx,
  crc16fr_res_if.source res
);
  import crc16fr_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0]  sync_byte;
  logic [LIMIT_W-1:0] max_frame_len;

  // Receive state.
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_count, byte_count_next;
  logic [LIMIT_W-1:0] frame_total, frame_total_next;
  logic [CRC_W-1:0]   crc_running, crc_running_next;
  logic [BYTE_W-1:0]  crc_high_byte, crc_high_byte_next;
  logic [BYTE_W-1:0]  len_high, len_high_next;

  // Result register.
  logic               res_valid;
  logic [BYTE_W-1:0]  byte_out;
  logic [POS_W-1:0]   byte_pos;
  logic               is_payload, frame_end, crc_match, len_error;
  logic               emit, emit_payload, emit_end, emit_match, emit_lerr;
  logic [POS_W-1:0]   emit_pos;

  // Datapath terms.
  logic               rx_xfer;
  logic [BYTE_W-1:0]  b;
  logic [CRC_W-1:0]   crc_base, crc_new;
  logic [TOTAL_W-1:0] total_calc;
  logic [LIMIT_W-1:0] limit;
  logic               len_ok;
  logic [LIMIT_W-1:0] pos_plus2;
  logic               body_mid, body_crc_hi;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !res_valid || res.ready;
  assign rx_xfer   = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= SYNC_RESET;
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SYNC_BYTE:     sync_byte     <= cfg.data[BYTE_W-1:0];
        REG_MAX_FRAME_LEN: max_frame_len <= cfg.data;
        default:           ;
      endcase
    end
  end

  // CRC, length check and body position compares.
  assign crc_base    = (phase == PH_HUNT) ? '0 : crc_running;
  assign crc_new     = crc_update(crc_base, b);
  assign total_calc  = TOTAL_W'({len_high, b}) + OVERHEAD_TOTAL;
  assign limit       = (max_frame_len > MAX_FRAME_LIMIT) ? MAX_FRAME_LIMIT : max_frame_len;
  assign len_ok      = (total_calc > OVERHEAD_TOTAL) &&
                       (total_calc <= TOTAL_W'(limit));
  assign pos_plus2   = LIMIT_W'(byte_count) + LIMIT_W'(2);
  assign body_mid    = pos_plus2 < frame_total;
  assign body_crc_hi = pos_plus2 == frame_total;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (rx_xfer) begin
      unique case (phase)
        PH_HUNT:   phase_next = (b == sync_byte) ? PH_LEN_HI : PH_HUNT;
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: phase_next = len_ok ? PH_BODY : PH_HUNT;
        PH_BODY:   phase_next = (body_mid || body_crc_hi) ? PH_BODY : PH_HUNT;
      endcase
    end
  end

  // Datapath updates and result fields.
  always_comb begin
    byte_count_next    = byte_count;
    frame_total_next   = frame_total;
    crc_running_next   = crc_running;
    crc_high_byte_next = crc_high_byte;
    len_high_next      = len_high;
    emit               = 1'b0;
    emit_pos           = byte_count;
    emit_payload       = 1'b0;
    emit_end           = 1'b0;
    emit_match         = 1'b0;
    emit_lerr          = 1'b0;
    if (rx_xfer) begin
      unique case (phase)
        PH_HUNT: begin
          if (b == sync_byte) begin
            emit             = 1'b1;
            emit_pos         = '0;
            crc_running_next = crc_new;
            byte_count_next  = POS_W'(1);
          end
        end
        PH_LEN_HI: begin
          emit             = 1'b1;
          crc_running_next = crc_new;
          len_high_next    = b;
          byte_count_next  = byte_count + POS_W'(1);
        end
        PH_LEN_LO: begin
          emit = 1'b1;
          if (len_ok) begin
            crc_running_next = crc_new;
            frame_total_next = total_calc[LIMIT_W-1:0];
            byte_count_next  = byte_count + POS_W'(1);
          end else begin
            emit_end           = 1'b1;
            emit_lerr          = 1'b1;
            byte_count_next    = '0;
            frame_total_next   = '0;
            crc_running_next   = '0;
            crc_high_byte_next = '0;
          end
        end
        PH_BODY: begin
          emit = 1'b1;
          if (body_mid) begin
            emit_payload     = 1'b1;
            crc_running_next = crc_new;
            byte_count_next  = byte_count + POS_W'(1);
          end else if (body_crc_hi) begin
            crc_high_byte_next = b;
            byte_count_next    = byte_count + POS_W'(1);
          end else begin
            emit_end           = 1'b1;
            emit_match         = crc_running == {crc_high_byte, b};
            byte_count_next    = '0;
            frame_total_next   = '0;
            crc_running_next   = '0;
            crc_high_byte_next = '0;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_count    <= '0;
      frame_total   <= '0;
      crc_running   <= '0;
      crc_high_byte <= '0;
      len_high      <= '0;
      res_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      frame_total   <= frame_total_next;
      crc_running   <= crc_running_next;
      crc_high_byte <= crc_high_byte_next;
      len_high      <= len_high_next;
      if (rx_xfer) begin
        res_valid <= emit;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload register, loaded when a byte produces a result.
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_out   <= b;
      byte_pos   <= emit_pos;
      is_payload <= emit_payload;
      frame_end  <= emit_end;
      crc_match  <= emit_match;
      len_error  <= emit_lerr;
    end
  end

  assign res.valid      = res_valid;
  assign res.byte_out   = byte_out;
  assign res.byte_pos   = byte_pos;
  assign res.is_payload = is_payload;
  assign res.frame_end  = frame_end;
  assign res.crc_match  = crc_match;
  assign res.len_error  = len_error;

  // A frame-ending byte always sends the receiver back to hunting.
  a_end_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (rx_xfer && emit && emit_end) |=> (phase == PH_HUNT && byte_count == '0))
    else $error("frame end did not return to hunting");

  // Flags on a delivered result are mutually consistent.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.crc_match || res.len_error)) |->
      (res.frame_end && !(res.crc_match && res.len_error) && !res.is_payload))
    else $error("inconsistent result flags");

  // A byte that starts a frame comes from hunting and sits at position zero.
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    (rx_xfer && phase == PH_HUNT && emit) |=> (res.valid && res.byte_pos == '0))
    else $error("sync byte not delivered at position zero");

  // Body bytes never run past the checked frame total.
  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (LIMIT_W'(byte_count) < frame_total &&
                            frame_total <= MAX_FRAME_LIMIT))
    else $error("body position beyond frame total");

endmodule

[tb/crc16fr_echo_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the frame receiver, predicts every echoed byte
// from the transfers on the input and configuration channels, and compares the
// results in order.
module crc16fr_echo_checker
  import crc16fr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  crc16fr_cfg_if cfg,
  crc16fr_rx_if  rx,
  crc16fr_res_if res,
  output int     errors,
  output int     pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [POS_W-1:0]  byte_pos;
    logic              is_payload;
    logic              frame_end;
    logic              crc_match;
    logic              len_error;
  } echo_t;

  echo_t pending_echoes[$];

  // Predictor copy of the registers.
  logic [BYTE_W-1:0]  sync_val;
  logic [LIMIT_W-1:0] max_len;

  // Predictor copy of the frame state.
  phase_t             rx_phase;
  logic [POS_W-1:0]   next_pos;
  logic [TOTAL_W-1:0] total;
  logic [CRC_W-1:0]   crc_acc;
  logic [BYTE_W-1:0]  crc_hi;

  // CRC-16/XMODEM advanced by one byte, one data bit at a time.
  function automatic logic [CRC_W-1:0] xmodem_next(input logic [CRC_W-1:0] c,
                                                   input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = c;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = r[CRC_W-1] ^ d[i];
      r = {r[CRC_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void restart_hunt();
    rx_phase = PH_HUNT;
    next_pos = '0;
    total    = '0;
    crc_acc  = '0;
    crc_hi   = '0;
  endfunction

  // Advances the frame state by one received byte and queues its echo, if any.
  task automatic predict_echo(input logic [BYTE_W-1:0] b);
    echo_t              e;
    logic [TOTAL_W-1:0] lim;
    logic [TOTAL_W-1:0] sum;
    bit                 produced;
    e = '0;
    e.byte_out = b;
    e.byte_pos = next_pos;
    produced = 1'b1;
    case (rx_phase)
      PH_LEN_HI: begin
        crc_acc  = xmodem_next(crc_acc, b);
        total    = {1'b0, b, 8'h00};
        rx_phase = PH_LEN_LO;
        next_pos++;
      end
      PH_LEN_LO: begin
        lim = (max_len > MAX_FRAME_LIMIT) ? TOTAL_W'(MAX_FRAME_LIMIT) : TOTAL_W'(max_len);
        sum = total + TOTAL_W'(b) + OVERHEAD_TOTAL;
        if (sum <= OVERHEAD_TOTAL || sum > lim) begin
          e.frame_end = 1'b1;
          e.len_error = 1'b1;
          restart_hunt();
        end else begin
          crc_acc  = xmodem_next(crc_acc, b);
          total    = sum;
          rx_phase = PH_BODY;
          next_pos++;
        end
      end
      PH_BODY: begin
        if (TOTAL_W'(next_pos) + 2 < total) begin
          e.is_payload = 1'b1;
          crc_acc = xmodem_next(crc_acc, b);
          next_pos++;
        end else if (TOTAL_W'(next_pos) + 2 == total) begin
          crc_hi = b;
          next_pos++;
        end else begin
          e.frame_end = 1'b1;
          e.crc_match = (crc_acc == {crc_hi, b});
          restart_hunt();
        end
      end
      default: begin
        // Anything but the sync byte is dropped while hunting.
        if (b == sync_val) begin
          crc_acc  = xmodem_next('0, b);
          rx_phase = PH_LEN_HI;
          next_pos = POS_W'(1);
          e.byte_pos = '0;
        end else begin
          produced = 1'b0;
        end
      end
    endcase
    if (produced) begin
      pending_echoes.push_back(e);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Results are compared before the input transfer of the same edge is
  // predicted, since a byte's echo never leaves in the cycle it arrives.
  always @(posedge clk) begin
    echo_t want;
    if (rst) begin
      sync_val = SYNC_RESET;
      max_len  = MAX_LEN_RESET;
      restart_hunt();
      pending_echoes.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (pending_echoes.size() == 0) begin
          $error("unexpected result: byte_out %0d, byte_pos %0d", res.byte_out,
                 res.byte_pos);
          errors++;
        end else begin
          want = pending_echoes.pop_front();
          check_field("byte_out", 16'(want.byte_out), 16'(res.byte_out));
          check_field("byte_pos", 16'(want.byte_pos), 16'(res.byte_pos));
          check_field("is_payload", 16'(want.is_payload), 16'(res.is_payload));
          check_field("frame_end", 16'(want.frame_end), 16'(res.frame_end));
          check_field("crc_match", 16'(want.crc_match), 16'(res.crc_match));
          check_field("len_error", 16'(want.len_error), 16'(res.len_error));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SYNC_BYTE:     sync_val = cfg.data[BYTE_W-1:0];
          REG_MAX_FRAME_LEN: max_len  = cfg.data;
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) begin
        predict_echo(rx.rx_byte);
      end
    end
    pending = pending_echoes.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import crc16fr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  crc16fr_cfg_if cfg_ch ();
  crc16fr_rx_if  rx_ch ();
  crc16fr_res_if res_ch ();

  int fail_count;
  int echo_pending;

  crc16_frame_receiver_top dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (rx_ch),
    .res (res_ch)
  );

  crc16fr_echo_checker chk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .rx      (rx_ch),
    .res     (res_ch),
    .errors  (fail_count),
    .pending (echo_pending)
  );

  // Register values as last written, used to shape the frames.
  logic [BYTE_W-1:0]  cur_sync = SYNC_RESET;
  logic [LIMIT_W-1:0] cur_max  = MAX_LEN_RESET;

  int gap_pct;
  int stall_pct;
  bit hold_req;
  int frame_items;

  // Offers one byte and waits for its transfer, then maybe idles for a burst.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int n;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 13);
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= 8'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Line noise between frames; never equal to the sync byte.
  task automatic send_noise(input int n);
    logic [BYTE_W-1:0] b;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      if (b == cur_sync) begin
        b = ~b;
      end
      send_byte(b);
    end
  endtask

  // Sends one frame with the given length field. A length that the current
  // limit rejects stops after the length bytes, as the receiver resumes hunting.
  task automatic send_frame(input logic [15:0] len, input bit crc_ok,
                            input bit extreme_fill);
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] lim;
    logic [CRC_W-1:0]   crc;
    logic [BYTE_W-1:0]  b;
    lim   = (cur_max > MAX_FRAME_LIMIT) ? TOTAL_W'(MAX_FRAME_LIMIT) : TOTAL_W'(cur_max);
    total = TOTAL_W'(len) + OVERHEAD_TOTAL;
    crc   = crc_update('0, cur_sync);
    crc   = crc_update(crc, len[15:8]);
    crc   = crc_update(crc, len[7:0]);
    send_byte(cur_sync);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    frame_items += 3;
    if (total <= OVERHEAD_TOTAL || total > lim) begin
      return;
    end
    for (int i = 0; i < int'(len); i++) begin
      if (extreme_fill) begin
        case (i % 3)
          0:       b = cur_sync;
          1:       b = 8'h00;
          default: b = 8'hFF;
        endcase
      end else begin
        b = 8'($urandom);
      end
      crc = crc_update(crc, b);
      send_byte(b);
    end
    if (!crc_ok) begin
      crc ^= 16'($urandom_range(1, 65535));
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    frame_items += int'(len) + 2;
  endtask

  // Mostly short well-formed frames; some noise, bad lengths and bad CRCs.
  task automatic random_frame();
    logic [LIMIT_W-1:0] lim;
    int                 r;
    int                 top_len;
    lim = (cur_max > MAX_FRAME_LIMIT) ? MAX_FRAME_LIMIT : cur_max;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_noise($urandom_range(1, 6));
    end else if (r < 16 || lim <= LIMIT_W'(FRAME_OVERHEAD)) begin
      case ($urandom_range(0, 3))
        0:       send_frame(16'h0000, 1'b1, 1'b0);
        1:       send_frame(16'hFFFF, 1'b1, 1'b0);
        2:       send_frame(16'(lim) - 16'd4, 1'b1, 1'b0);
        default: send_frame(16'($urandom), 1'b1, 1'b0);
      endcase
    end else begin
      top_len = int'(lim) - int'(FRAME_OVERHEAD);
      if (r >= 98 && top_len > 200) begin
        top_len = 200;
      end else if (r < 98 && top_len > 24) begin
        top_len = 24;
      end
      send_frame(16'($urandom_range(1, top_len)), $urandom_range(0, 9) != 0, r == 97);
    end
  endtask

  // Waits until every predicted echo has been transferred, plus a margin.
  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (echo_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [LIMIT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SYNC_BYTE: cur_sync = val[BYTE_W-1:0];
      default:       cur_max  = val;
    endcase
  endtask

  // One configuration setting followed by random frames.
  task automatic run_phase(input logic [BYTE_W-1:0] sync, input logic [LIMIT_W-1:0] max_l,
                           input int gap, input int stall, input int target);
    int start;
    settle();
    write_reg(REG_SYNC_BYTE, {3'($urandom), sync});
    write_reg(REG_MAX_FRAME_LEN, max_l);
    gap_pct   = gap;
    stall_pct = stall;
    start     = frame_items;
    while (frame_items - start < target) random_frame();
  endtask

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int n;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_SYNC_BYTE;
    cfg_ch.data   <= '0;
    gap_pct   = 20;
    stall_pct = 20;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'd0, 1'b1, 1'b0);     // Total equal to the overhead.
    send_frame(16'd1, 1'b1, 1'b0);     // Shortest legal frame.
    send_frame(16'd3, 1'b1, 1'b1);     // Sync and extreme values inside the payload.
    send_frame(16'd1, 1'b0, 1'b0);     // CRC mismatch, still delivered.
    send_frame(16'hFFFF, 1'b1, 1'b0);  // Largest length field.
    send_frame(16'd1020, 1'b1, 1'b0);  // One byte over the limit.

    run_phase(8'h00, 11'd6, 25, 25, 40);
    run_phase(8'hFF, 11'h7FF, 15, 15, 60);

    // Register above the cap; the result side holds off during a long frame
    // whose positions reach past 512.
    hold_req = 1'b1;
    send_frame(16'd515, 1'b1, 1'b0);
    send_frame(16'd1020, 1'b1, 1'b0);

    run_phase(8'($urandom), 11'd0, 40, 10, 20);
    run_phase(8'($urandom), 11'd5, 10, 40, 20);
    run_phase(8'($urandom), 11'($urandom_range(6, 1024)), 20, 20, 50);
    run_phase(SYNC_RESET, MAX_LEN_RESET, 0, 0, 50);

    // Drain with a bound, then give the verdict.
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    n = 0;
    while (echo_pending != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (echo_pending != 0) begin
      $error("%0d expected results never arrived", echo_pending);
    end
    if (fail_count == 0 && echo_pending == 0) begin
      $display("** crc16_frame_receiver_top: PASSED **");
    end else begin
      $display("** crc16_frame_receiver_top: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("** crc16_frame_receiver_top: FAILED **");
    $finish;
  end

endmodule

[sim.f]
sv/crc16fr_pkg.sv
sv/crc16fr_if.sv
sv/crc16_frame_receiver_top.sv
tb/crc16fr_echo_checker.sv
tb/tb_top.sv
